>>> rtl/core/bgf_pkg.sv
// Shared constants for the battery gauge filter.
`default_nettype none

package bgf_pkg;

  localparam int DEPTH_DEFAULT = 8;

  localparam int VCODE_W = 20;
  localparam int WORD_W  = 24;
  localparam int CFG_W   = 20;
  localparam int CFGI_W  = 2;
  localparam int PCT_W   = 15;
  localparam int MAXI_W  = 16;
  localparam int CURMA_W = 17;
  localparam int POWER_W = 36;

  localparam int CUR_SHIFT = 19;

  // shared divider: 36-bit signed dividend, 21-bit unsigned divisor
  localparam int DIV_NW = 36;
  localparam int DIV_DW = 21;

  localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

  localparam logic [CFGI_W-1:0] CFG_EMPTY = 2'd0;
  localparam logic [CFGI_W-1:0] CFG_FULL  = 2'd1;
  localparam logic [CFGI_W-1:0] CFG_LOW   = 2'd2;
  localparam logic [CFGI_W-1:0] CFG_MAXI  = 2'd3;

  localparam logic signed [VCODE_W-1:0] EMPTY_RESET = 20'sd92160;
  localparam logic signed [VCODE_W-1:0] FULL_RESET  = 20'sd129024;
  localparam logic [PCT_W-1:0]          LOW_RESET   = 15'd5120;
  localparam logic [MAXI_W-1:0]         MAXI_RESET  = 16'd10000;

endpackage

`default_nettype wire

>>> rtl/core/bgf_div.sv
// Sequential floor divider, signed dividend by positive divisor, two bits per cycle.
`default_nettype none

module bgf_div #(
  parameter int NW = bgf_pkg::DIV_NW,
  parameter int DW = bgf_pkg::DIV_DW
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [NW-1:0] dividend,
  input  wire logic [DW-1:0]        divisor,
  output logic                      done,
  output logic signed [NW-1:0]      quotient
);

  localparam int STEPS = NW / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW:0]      rem;
  logic [NW-1:0]    qsr;
  logic [DW-1:0]    dvs;
  logic             neg;

  logic [DW:0]      rem_next;
  logic [NW-1:0]    qsr_next;

  always_comb begin
    logic [DW:0]   r;
    logic [NW-1:0] q;
    r = rem;
    q = qsr;
    for (int k = 0; k < 2; k++) begin
      r = {r[DW-1:0], q[NW-1]};
      q = {q[NW-2:0], 1'b0};
      if (r >= {1'b0, dvs}) begin
        r = r - {1'b0, dvs};
        q[0] = 1'b1;
      end
    end
    rem_next = r;
    qsr_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(STEPS);
        neg  <= dividend[NW-1];
        qsr  <= dividend[NW-1] ? NW'(-dividend) : NW'(dividend);
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= rem_next;
        qsr <= qsr_next;
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor: -(q) - 1 == ~q when the remainder is nonzero
  always_comb begin
    if (!neg) begin
      quotient = $signed(qsr);
    end else if (rem != '0) begin
      quotient = $signed(~qsr);
    end else begin
      quotient = $signed(-qsr);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/battery_gauge_filter.sv
// Battery gauge: moving averages of voltage and current, power, charge percent, low flag.
//
//   channel  direction        signals
//   in       source -> block  in_valid, in_stall, bus_voltage_word, current_word
//   out      block -> sink    out_valid, out_stall, avg_voltage_code .. battery_low
//   cfg      host -> block    cfg_write, cfg_index, cfg_data
//
// One item at a time; in_stall stays high until the result is in the output register. The
// percent divide sets the time from accept to result and is skipped when the percent clamps.
// DEPTH must be a power of two (unchecked); averages: arithmetic shifts of running sums.
// Rings live in one memory of DEPTH entries; per-entry valid flags clear at reset.
// Reset is synchronous; config returns to its reset values.
// A finished result waits in the output register while the next item is accepted.
`default_nettype none

module battery_gauge_filter #(
  parameter int DEPTH = bgf_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,

  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [bgf_pkg::WORD_W-1:0]            bus_voltage_word,
  input  wire logic [bgf_pkg::WORD_W-1:0]            current_word,

  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [bgf_pkg::VCODE_W-1:0]         avg_voltage_code,
  output logic signed [bgf_pkg::CURMA_W-1:0]         avg_current_ma,
  output logic signed [bgf_pkg::POWER_W-1:0]         power_product,
  output logic [bgf_pkg::PCT_W-1:0]                  charge_percent_q8,
  output logic                                       battery_low,

  input  wire logic                                  cfg_write,
  input  wire logic [bgf_pkg::CFGI_W-1:0]            cfg_index,
  input  wire logic [bgf_pkg::CFG_W-1:0]             cfg_data
);

  localparam int VW    = bgf_pkg::VCODE_W;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W = VW + $clog2(DEPTH);
  localparam int NW    = bgf_pkg::DIV_NW;
  localparam int DW    = bgf_pkg::DIV_DW;
  localparam int PROD_W = VW + bgf_pkg::MAXI_W + 1;
  localparam int NUM_W  = VW + bgf_pkg::PCT_W;
  localparam int PWR_W  = VW + bgf_pkg::CURMA_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_AVG  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_PCT  = 3'd5;
  localparam logic [2:0] S_PW   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state;

  // configuration
  logic signed [VW-1:0]               empty_code;
  logic signed [VW-1:0]               full_code;
  logic [bgf_pkg::PCT_W-1:0]          low_pct;
  logic [bgf_pkg::MAXI_W-1:0]         max_ma;

  // ring memory, voltage in the upper half
  logic [2*VW-1:0]   ring_mem [DEPTH];
  logic [2*VW-1:0]   ring_rdata;
  logic [DEPTH-1:0]  ring_valid;
  logic [PW-1:0]     pos;

  logic signed [VW-1:0]    vcode;
  logic signed [VW-1:0]    icode;
  logic signed [VW-1:0]    old_v;
  logic signed [VW-1:0]    old_i;
  logic signed [SUM_W-1:0] vsum;
  logic signed [SUM_W-1:0] isum;

  logic signed [VW-1:0]                avg_v;
  logic signed [VW-1:0]                avg_i;
  logic signed [PROD_W-1:0]            prod_i;
  logic signed [bgf_pkg::CURMA_W-1:0]  cur_ma;
  logic signed [VW:0]                  diff;
  logic [NUM_W-1:0]                    pct_num;
  logic signed [PWR_W-1:0]             power_full;
  logic signed [bgf_pkg::POWER_W-1:0]  power;
  logic [bgf_pkg::PCT_W-1:0]           pct;

  logic                 pct_full;
  logic                 pct_empty;
  logic signed [VW:0]   den;

  logic                 div_start;
  logic signed [NW-1:0] div_dividend;
  logic [DW-1:0]        div_divisor;
  logic                 div_done;
  logic signed [NW-1:0] div_quotient;

  logic in_accept;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign old_v = ring_valid[pos] ? $signed(ring_rdata[2*VW-1:VW]) : '0;
  assign old_i = ring_valid[pos] ? $signed(ring_rdata[VW-1:0])    : '0;

  assign pct_full  = (avg_v >= full_code);
  assign pct_empty = (avg_v <= empty_code);
  assign den       = (VW+1)'(full_code) - (VW+1)'(empty_code);

  assign power_full = avg_v * cur_ma;

  always_comb begin
    div_start    = 1'b0;
    div_dividend = $signed(NW'(pct_num));
    div_divisor  = DW'(den[VW-1:0]);
    case (state)
      S_PCT: begin
        div_start = !pct_full && !pct_empty;
      end
      default: begin
      end
    endcase
  end

  bgf_div #(
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_code <= bgf_pkg::EMPTY_RESET;
      full_code  <= bgf_pkg::FULL_RESET;
      low_pct    <= bgf_pkg::LOW_RESET;
      max_ma     <= bgf_pkg::MAXI_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        bgf_pkg::CFG_EMPTY: empty_code <= $signed(cfg_data[VW-1:0]);
        bgf_pkg::CFG_FULL:  full_code  <= $signed(cfg_data[VW-1:0]);
        bgf_pkg::CFG_LOW:   low_pct    <= cfg_data[bgf_pkg::PCT_W-1:0];
        bgf_pkg::CFG_MAXI:  max_ma     <= cfg_data[bgf_pkg::MAXI_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ring memory
  always_ff @(posedge clk) begin
    if (in_accept) begin
      ring_rdata <= ring_mem[pos];
    end
    if (state == S_UPD) begin
      ring_mem[pos] <= {vcode, icode};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ring_valid <= '0;
      pos        <= '0;
      vsum       <= '0;
      isum       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            vcode <= $signed(bus_voltage_word[bgf_pkg::WORD_W-1:4]);
            icode <= $signed(current_word[bgf_pkg::WORD_W-1:4]);
            state <= S_UPD;
          end
        end
        S_UPD: begin
          vsum            <= vsum + SUM_W'(vcode) - SUM_W'(old_v);
          isum            <= isum + SUM_W'(icode) - SUM_W'(old_i);
          ring_valid[pos] <= 1'b1;
          pos             <= (pos == PW'(DEPTH - 1)) ? '0 : pos + PW'(1);
          state           <= S_AVG;
        end
        S_AVG: begin
          avg_v <= vsum[SUM_W-1:SUM_W-VW];
          avg_i <= isum[SUM_W-1:SUM_W-VW];
          state <= S_MUL1;
        end
        S_MUL1: begin
          prod_i <= avg_i * $signed({1'b0, max_ma});
          diff   <= (VW+1)'(avg_v) - (VW+1)'(empty_code);
          state  <= S_MUL2;
        end
        S_MUL2: begin
          cur_ma  <= prod_i[bgf_pkg::CUR_SHIFT + bgf_pkg::CURMA_W - 1:bgf_pkg::CUR_SHIFT];
          pct_num <= NUM_W'(diff[VW-1:0]) * NUM_W'(bgf_pkg::PCT_FULL);
          state   <= S_PCT;
        end
        S_PCT: begin
          power <= power_full[bgf_pkg::POWER_W-1:0];
          if (pct_full) begin
            pct   <= bgf_pkg::PCT_FULL;
            state <= S_OUT;
          end else if (pct_empty) begin
            pct   <= '0;
            state <= S_OUT;
          end else begin
            state <= S_PW;
          end
        end
        S_PW: begin
          if (div_done) begin
            pct   <= div_quotient[bgf_pkg::PCT_W-1:0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            avg_voltage_code  <= avg_v;
            avg_current_ma    <= cur_ma;
            power_product     <= power;
            charge_percent_q8 <= pct;
            battery_low       <= (pct < low_pct);
            out_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sim/tb_battery_gauge_filter.sv
// Testbench for battery_gauge_filter: queued sample driver, result monitor, gauge predictor.
module tb_battery_gauge_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = bgf_pkg::DEPTH_DEFAULT;
  localparam int AVG_SHIFT = $clog2(DEPTH);

  typedef struct {
    logic [bgf_pkg::WORD_W-1:0] volt;
    logic [bgf_pkg::WORD_W-1:0] curr;
  } sample_t;

  typedef struct {
    logic signed [bgf_pkg::VCODE_W-1:0] avg_v;
    logic signed [bgf_pkg::CURMA_W-1:0] cur_ma;
    logic signed [bgf_pkg::POWER_W-1:0] power;
    logic [bgf_pkg::PCT_W-1:0]          pct;
    logic                               low;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [bgf_pkg::WORD_W-1:0] bus_voltage_word = '0;
  logic [bgf_pkg::WORD_W-1:0] current_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [bgf_pkg::VCODE_W-1:0] avg_voltage_code;
  logic signed [bgf_pkg::CURMA_W-1:0] avg_current_ma;
  logic signed [bgf_pkg::POWER_W-1:0] power_product;
  logic [bgf_pkg::PCT_W-1:0] charge_percent_q8;
  logic battery_low;
  logic cfg_write = 1'b0;
  logic [bgf_pkg::CFGI_W-1:0] cfg_index = bgf_pkg::CFG_EMPTY;
  logic [bgf_pkg::CFG_W-1:0] cfg_data = '0;

  battery_gauge_filter dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .bus_voltage_word(bus_voltage_word), .current_word(current_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .avg_voltage_code(avg_voltage_code), .avg_current_ma(avg_current_ma),
    .power_product(power_product), .charge_percent_q8(charge_percent_q8),
    .battery_low(battery_low),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // gauge state mirrored from the block
  longint volt_ring [DEPTH];
  longint curr_ring [DEPTH];
  int     ring_pos = 0;
  longint volt_sum = 0;
  longint curr_sum = 0;
  logic signed [bgf_pkg::VCODE_W-1:0] cfg_empty = bgf_pkg::EMPTY_RESET;
  logic signed [bgf_pkg::VCODE_W-1:0] cfg_full  = bgf_pkg::FULL_RESET;
  logic [bgf_pkg::PCT_W-1:0]          cfg_low   = bgf_pkg::LOW_RESET;
  logic [bgf_pkg::MAXI_W-1:0]         cfg_maxi  = bgf_pkg::MAXI_RESET;

  sample_t  pending_samples[$];
  reading_t expected_readings[$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  int  in_gap = 0;
  int  out_gap = 0;

  initial begin
    for (int k = 0; k < DEPTH; k++) begin
      volt_ring[k] = 0;
      curr_ring[k] = 0;
    end
  end

  function automatic reading_t gauge_predict(sample_t s);
    reading_t r;
    longint vc, ic, avg_v, avg_i, cma, pw, pct;
    vc = longint'(signed'(s.volt[bgf_pkg::WORD_W-1:4]));
    ic = longint'(signed'(s.curr[bgf_pkg::WORD_W-1:4]));
    volt_sum += vc - volt_ring[ring_pos];
    curr_sum += ic - curr_ring[ring_pos];
    volt_ring[ring_pos] = vc;
    curr_ring[ring_pos] = ic;
    ring_pos = (ring_pos + 1) % DEPTH;
    avg_v = volt_sum >>> AVG_SHIFT;
    avg_i = curr_sum >>> AVG_SHIFT;
    cma = (avg_i * longint'(cfg_maxi)) >>> bgf_pkg::CUR_SHIFT;
    pw = avg_v * cma;
    // full clamp is tested first and wins a tie; a window that is empty or inverted never divides
    if (avg_v >= longint'(cfg_full))
      pct = longint'(bgf_pkg::PCT_FULL);
    else if (avg_v <= longint'(cfg_empty))
      pct = 0;
    else
      pct = ((avg_v - longint'(cfg_empty)) * longint'(bgf_pkg::PCT_FULL)) /
            (longint'(cfg_full) - longint'(cfg_empty));
    r.avg_v  = avg_v[bgf_pkg::VCODE_W-1:0];
    r.cur_ma = cma[bgf_pkg::CURMA_W-1:0];
    r.power  = pw[bgf_pkg::POWER_W-1:0];
    r.pct    = pct[bgf_pkg::PCT_W-1:0];
    r.low    = pct < longint'(cfg_low);
    return r;
  endfunction

  function automatic int next_gap();
    if (calm || $urandom_range(99) >= 7) return 0;
    return ($urandom_range(7) == 0) ? int'($urandom_range(70, 2)) : 1;
  endfunction

  // driver
  always @(posedge clk) begin
    sample_t s;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s.volt = bus_voltage_word;
        s.curr = current_word;
        expected_readings.push_back(gauge_predict(s));
      end
      if (!in_valid || !in_stall) begin
        if (in_gap == 0) in_gap = next_gap();
        if (in_gap > 0 || pending_samples.size() == 0) begin
          if (in_gap > 0) in_gap--;
          in_valid <= 1'b0;
        end else begin
          s = pending_samples.pop_front();
          in_valid <= 1'b1;
          bus_voltage_word <= s.volt;
          current_word <= s.curr;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reading_t got, want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.avg_v  = avg_voltage_code;
        got.cur_ma = avg_current_ma;
        got.power  = power_product;
        got.pct    = charge_percent_q8;
        got.low    = battery_low;
        if (expected_readings.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item v=%0d i=%0d p=%0d pct=%0d low=%0b",
                     got.avg_v, got.cur_ma, got.power, got.pct, got.low);
          mismatches++;
        end else begin
          want = expected_readings.pop_front();
          if (got.avg_v !== want.avg_v || got.cur_ma !== want.cur_ma ||
              got.power !== want.power || got.pct !== want.pct ||
              got.low !== want.low) begin
            if (mismatches < 10)
              $display({"mismatch exp v=%0d i=%0d p=%0d pct=%0d low=%0b,",
                        " got v=%0d i=%0d p=%0d pct=%0d low=%0b"},
                       want.avg_v, want.cur_ma, want.power, want.pct, want.low,
                       got.avg_v, got.cur_ma, got.power, got.pct, got.low);
            mismatches++;
          end
        end
      end
      if (out_gap == 0) out_gap = next_gap();
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic cfg_put(logic [bgf_pkg::CFGI_W-1:0] idx, logic [bgf_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      bgf_pkg::CFG_EMPTY: cfg_empty = data;
      bgf_pkg::CFG_FULL:  cfg_full = data;
      bgf_pkg::CFG_LOW:   cfg_low = data[bgf_pkg::PCT_W-1:0];
      bgf_pkg::CFG_MAXI:  cfg_maxi = data[bgf_pkg::MAXI_W-1:0];
      default: ;
    endcase
  endtask

  // upper data bits beyond a register's width carry junk
  task automatic set_config(int e, int f, int lo, int mx);
    cfg_put(bgf_pkg::CFG_EMPTY, 20'(e));
    cfg_put(bgf_pkg::CFG_FULL, 20'(f));
    cfg_put(bgf_pkg::CFG_LOW, {5'($urandom), 15'(lo)});
    cfg_put(bgf_pkg::CFG_MAXI, {4'($urandom), 16'(mx)});
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    longint lo, hi, span, code;
    int pick;
    lo = (cfg_empty < cfg_full) ? longint'(cfg_empty) : longint'(cfg_full);
    hi = (cfg_empty < cfg_full) ? longint'(cfg_full) : longint'(cfg_empty);
    span = hi - lo + 1;
    lo = lo - span / 4 - 16;
    hi = hi + span / 4 + 16;
    if (lo < -524288) lo = -524288;
    if (hi > 524287) hi = 524287;
    code = lo + longint'($urandom_range(32'(hi - lo)));
    pick = $urandom_range(99);
    if (pick < 65)
      s.volt = {20'(code), 4'($urandom_range(15))};
    else if (pick < 85)
      s.volt = 24'($urandom);
    else
      case ($urandom_range(3))
        0: s.volt = 24'h000000;
        1: s.volt = 24'hFFFFFF;
        2: s.volt = 24'h7FFFFF;
        default: s.volt = 24'h800000;
      endcase
    pick = $urandom_range(99);
    if (pick < 70)
      s.curr = 24'($urandom);
    else if (pick < 85)
      s.curr = 24'(int'($urandom_range(65535)) - 32768);
    else
      case ($urandom_range(3))
        0: s.curr = 24'h000000;
        1: s.curr = 24'hFFFFFF;
        2: s.curr = 24'h7FFFFF;
        default: s.curr = 24'h800000;
      endcase
    return s;
  endfunction

  task automatic run_random(int n);
    repeat (n) pending_samples.push_back(random_sample());
    drain();
  endtask

  initial begin
    int e, f;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // ramp-up from the cleared rings, then the extremes of both words
    repeat (8) pending_samples.push_back('{24'((110000 << 4) | 15), 24'h7FFFFF});
    repeat (8) pending_samples.push_back('{24'h800000, 24'h800000});
    pending_samples.push_back('{24'hFFFFFF, 24'hFFFFFF});
    pending_samples.push_back('{24'h7FFFFF, 24'h000000});
    pending_samples.push_back('{24'h000000, 24'h00000F});
    pending_samples.push_back('{24'(129024 << 4), 24'hFFFFF0});
    pending_samples.push_back('{24'(92160 << 4), 24'h000010});
    pending_samples.push_back('{24'h5A5A5A, 24'hA5A5A5});
    pending_samples.push_back('{24'hA5A5A5, 24'h5A5A5A});
    drain();
    run_random(200);

    set_config(-524288, 524287, 25600, 65535);
    run_random(200);
    // inverted window and zero current scale
    set_config(524287, -524288, 0, 0);
    run_random(150);
    // empty window, threshold above full scale
    set_config(100000, 100000, 32767, 1);
    run_random(150);

    repeat (4) begin
      e = int'($urandom_range(950000)) - 524288;
      f = e + 1 + int'($urandom_range(32'((524286 - e) >> $urandom_range(10))));
      set_config(e, f, int'($urandom_range(25600)), int'($urandom_range(65535, 1)));
      run_random(200);
    end

    calm = 1'b1;
    set_config(int'(bgf_pkg::EMPTY_RESET), int'(bgf_pkg::FULL_RESET),
               int'(bgf_pkg::LOW_RESET), int'(bgf_pkg::MAXI_RESET));
    run_random(150);
    calm = 1'b0;

    repeat (100) @(posedge clk);
    mismatches += expected_readings.size();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bgf_pkg.sv
rtl/core/bgf_div.sv
rtl/core/battery_gauge_filter.sv
sim/tb_battery_gauge_filter.sv
